// ===== design/lrupr_pkg.sv =====
// Package for the LRU page replacement core: sizes, register map and
// the structs passed along the cell chain. No dependencies.
package lrupr_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W  = 4;
    localparam int ADDR_W = 3;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);
    localparam logic             REG_FRAMES   = 1'b0;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [RANK_W:0]      old_rank_t;
    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam rank_t     RANK_MAX  = rank_t'(NUM_FRAMES - 1);
    localparam old_rank_t RANK_NONE = old_rank_t'(NUM_FRAMES);
    localparam logic [31:0] FAULT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic  hit_found;
        idx_t  hit_idx;
        rank_t hit_rank;
        logic  empty_found;
        idx_t  empty_idx;
        logic  best_found;
        idx_t  best_idx;
        rank_t best_rank;
        page_t best_page;
    } acc_t;

    typedef struct packed {
        logic      en;
        logic      clear;
        logic      miss;
        idx_t      frame;
        old_rank_t old_rank;
        page_t     page;
    } upd_t;

endpackage

// ===== design/lrupr_cell.sv =====
// One frame cell: holds page, valid and recency rank, folds its entry into
// the search record from its neighbor, and applies the broadcast update.
// Depends on lrupr_pkg.
module lrupr_cell
    import lrupr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  idx_t cell_idx,
    input  logic active,
    input  page_t key,
    input  acc_t acc_in,
    output acc_t acc_out,
    input  upd_t upd
);

    logic  valid_reg;
    logic  valid_next;
    rank_t rank_reg;
    rank_t rank_next;
    page_t page_reg;
    page_t page_next;
    acc_t  acc_reg;
    acc_t  acc_next;
    logic  selected;
    logic  older;

    always_comb
    begin
        acc_next = acc_in;
        if (active && valid_reg)
        begin
            if (page_reg == key && !acc_in.hit_found)
            begin
                acc_next.hit_found = 1'b1;
                acc_next.hit_idx   = cell_idx;
                acc_next.hit_rank  = rank_reg;
            end
            if (!acc_in.best_found || rank_reg > acc_in.best_rank)
            begin
                acc_next.best_found = 1'b1;
                acc_next.best_idx   = cell_idx;
                acc_next.best_rank  = rank_reg;
                acc_next.best_page  = page_reg;
            end
        end
        if (active && !valid_reg && !acc_in.empty_found)
        begin
            acc_next.empty_found = 1'b1;
            acc_next.empty_idx   = cell_idx;
        end
    end

    assign selected = active && (cell_idx == upd.frame);
    assign older    = active && valid_reg && ({1'b0, rank_reg} < upd.old_rank)
                      && (rank_reg != RANK_MAX);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        page_next  = page_reg;
        if (upd.en)
        begin
            if (selected)
            begin
                rank_next = '0;
                if (upd.miss)
                begin
                    valid_next = 1'b1;
                    page_next  = upd.page;
                end
            end
            else if (older)
            begin
                rank_next = rank_reg + rank_t'(1);
            end
            if (upd.clear)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        acc_reg  <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

// ===== design/lrupr_cfg.sv =====
// APB register block holding frames_in_use and deriving the active frame
// count. Depends on lrupr_pkg.
module lrupr_cfg
    import lrupr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cnt_t              active_count
);

    logic [CFG_W-1:0] frames_reg;
    logic [CFG_W-1:0] frames_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAMES);

    always_comb
    begin
        frames_next = frames_reg;
        if (wr_en)
        begin
            frames_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
        end
        else
        begin
            frames_reg <= frames_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAMES)
        begin
            prdata = {{(32-CFG_W){1'b0}}, frames_reg};
        end
    end

    always_comb
    begin
        if (frames_reg == '0)
        begin
            active_count = cnt_t'(1);
        end
        else if (int'(frames_reg) > NUM_FRAMES)
        begin
            active_count = cnt_t'(NUM_FRAMES);
        end
        else
        begin
            active_count = cnt_t'(frames_reg);
        end
    end

endmodule

// ===== design/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement core: control, cell chain and
// result register. Depends on lrupr_pkg, lrupr_cell and lrupr_cfg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries page_number and last_access.
//   Output channel (out_valid/out_stall) carries hit, frame_index,
//   evicted_valid, evicted_page and fault_count, one result per transaction.
//   A transaction is taken when valid is high and stall is low.
//   The search record walks the frame cells one cell per cycle, then the
//   update state applies the update to all cells and registers the result.
//   A new transaction is taken while a finished result still waits in the
//   output register; its update holds while the receiver stalls.
//   The input stalls from acceptance until the update is done.
//   last_access clears frames, ranks and the fault count after its result.
//   Reset: all frames empty, ranks zero, fault count zero, frames_in_use 8.
//   frames_in_use is written through the APB port by the user, who must do
//   so only while the core is idle; the core itself does not enforce this.
module lru_page_replacement_core
    import lrupr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       page_number,
    input  logic              last_access,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [2:0]        frame_index,
    output logic              evicted_valid,
    output logic [15:0]       evicted_page,
    output logic [31:0]       fault_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t      state_reg;
    cnt_t        cnt_reg;
    page_t       key_reg;
    logic        last_reg;
    logic [31:0] fault_reg;
    logic        out_valid_reg;
    logic        hit_reg;
    idx_t        frame_reg;
    logic        ev_valid_reg;
    page_t       ev_page_reg;
    logic [31:0] fault_out_reg;

    cnt_t        active_count;
    acc_t        acc_chain [NUM_FRAMES+1];
    acc_t        tail;
    upd_t        upd;
    logic        in_accept;
    logic        slot_free;
    logic        ev_valid;
    page_t       ev_page;
    logic [31:0] fault_next;

    lrupr_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .active_count (active_count)
    );

    assign acc_chain[0] = '0;

    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        lrupr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (idx_t'(i)),
            .active   (cnt_t'(i) < active_count),
            .key      (key_reg),
            .acc_in   (acc_chain[i]),
            .acc_out  (acc_chain[i+1]),
            .upd      (upd)
        );
    end

    assign tail      = acc_chain[NUM_FRAMES];
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        upd.en    = (state_reg == ST_UPDATE) && slot_free;
        upd.clear = last_reg;
        upd.miss  = !tail.hit_found;
        upd.page  = key_reg;
        ev_valid  = 1'b0;
        ev_page   = '0;
        if (tail.hit_found)
        begin
            upd.frame    = tail.hit_idx;
            upd.old_rank = {1'b0, tail.hit_rank};
        end
        else if (tail.empty_found)
        begin
            upd.frame    = tail.empty_idx;
            upd.old_rank = RANK_NONE;
        end
        else
        begin
            upd.frame    = tail.best_idx;
            upd.old_rank = {1'b0, tail.best_rank};
            ev_valid     = 1'b1;
            ev_page      = tail.best_page;
        end
        fault_next = fault_reg;
        if (!tail.hit_found && fault_reg != FAULT_MAX)
        begin
            fault_next = fault_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    cnt_reg <= cnt_reg + cnt_t'(1);
                    if (cnt_reg == cnt_t'(NUM_FRAMES - 1))
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (slot_free)
                    begin
                        fault_reg <= last_reg ? '0 : fault_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg  <= page_number[PAGE_BITS-1:0];
            last_reg <= last_access;
        end
        if (upd.en)
        begin
            hit_reg       <= tail.hit_found;
            frame_reg     <= upd.frame;
            ev_valid_reg  <= ev_valid;
            ev_page_reg   <= ev_page;
            fault_out_reg <= fault_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = 3'(frame_reg);
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = 16'(ev_page_reg);
    assign fault_count   = fault_out_reg;

`ifndef NO_ASSERTIONS
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_UPDATE))
        else $error("result appeared without an update cycle");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid))
        else $error("hit reported together with an eviction");

    a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> fault_count != 32'd0)
        else $error("fault reported with zero fault count");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |=> (state_reg != ST_IDLE))
        else $error("search ended without an update cycle");
`endif

endmodule

// ===== tb/lru_page_replacement_core_tb.sv =====
// Self-checking testbench for lru_page_replacement_core: directed table then random
// reference streams, each result checked against its table value or an in-bench LRU predictor.
// Depends on lrupr_pkg and the core RTL.
module lru_page_replacement_core_tb;
    import lrupr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ACCESSES = 950;
    localparam int CALM_TAIL      = 100;
    localparam int DRAIN_CYCLES   = 2 * (NUM_FRAMES + 2);

    typedef struct packed {
        logic        hit;
        logic [2:0]  frame;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] faults;
    } page_outcome_t;

    typedef enum logic [1:0] {ROW_ACCESS, ROW_KNOWN, ROW_FRAMES} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [15:0]   value;
        logic          last_flag;
        page_outcome_t want;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [15:0]       page_number;
    logic              last_access;
    logic              out_valid;
    logic              out_stall;
    logic              hit;
    logic [2:0]        frame_index;
    logic              evicted_valid;
    logic [15:0]       evicted_page;
    logic [31:0]       fault_count;

    page_t            slot_page [NUM_FRAMES];
    logic             slot_full [NUM_FRAMES];
    rank_t            slot_rank [NUM_FRAMES];
    logic [31:0]      fault_tally;
    logic [CFG_W-1:0] frames_setting;

    page_outcome_t pending_outcomes[$];
    int            accesses_sent;
    int            mismatch_count;
    logic          calm;

    lru_page_replacement_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .last_access   (last_access),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_frames();
        int i;
        for (i = 0; i < NUM_FRAMES; i++)
        begin
            slot_page[i] = '0;
            slot_full[i] = 1'b0;
            slot_rank[i] = '0;
        end
        fault_tally = '0;
    endfunction

    // Look up one page, update recency and residency, return the predicted result.
    function automatic page_outcome_t lru_lookup(page_t page, logic last_flag);
        page_outcome_t res;
        int            act;
        int            f;
        int            prior;
        int            i;
        logic          found;
        logic          empty;
        res   = '0;
        found = 1'b0;
        empty = 1'b0;
        f     = 0;
        if (frames_setting == 0)
            act = 1;
        else if (frames_setting > NUM_FRAMES)
            act = NUM_FRAMES;
        else
            act = int'(frames_setting);
        for (i = 0; i < act; i++)
        begin
            if (!found && slot_full[i] && slot_page[i] == page)
            begin
                f     = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            prior = slot_rank[f];
        end
        else
        begin
            if (fault_tally != FAULT_MAX)
                fault_tally++;
            for (i = 0; i < act; i++)
            begin
                if (!empty && !slot_full[i])
                begin
                    f     = i;
                    empty = 1'b1;
                end
            end
            if (empty)
            begin
                prior = NUM_FRAMES;
            end
            else
            begin
                f = 0;
                for (i = 1; i < act; i++)
                begin
                    if (slot_rank[i] > slot_rank[f])
                        f = i;
                end
                res.ev_valid = 1'b1;
                res.ev_page  = slot_page[f];
                prior        = slot_rank[f];
            end
        end
        for (i = 0; i < act; i++)
        begin
            if (i != f && slot_full[i] && slot_rank[i] < prior && slot_rank[i] != RANK_MAX)
                slot_rank[i]++;
        end
        slot_rank[f] = '0;
        if (!found)
        begin
            slot_page[f] = page;
            slot_full[f] = 1'b1;
        end
        res.hit    = found;
        res.frame  = 3'(f);
        res.faults = fault_tally;
        if (last_flag)
            clear_frames();
        return res;
    endfunction

    function automatic script_row_t access_row(logic [15:0] page, logic last_flag);
        script_row_t r;
        r.kind      = ROW_ACCESS;
        r.value     = page;
        r.last_flag = last_flag;
        r.want      = '0;
        return r;
    endfunction

    function automatic script_row_t known_row(logic [15:0] page, logic last_flag, logic h,
                                              logic [2:0] f, logic ev, logic [15:0] evp,
                                              logic [31:0] faults);
        script_row_t r;
        r.kind      = ROW_KNOWN;
        r.value     = page;
        r.last_flag = last_flag;
        r.want      = '{h, f, ev, evp, faults};
        return r;
    endfunction

    function automatic script_row_t frames_row(logic [CFG_W-1:0] v);
        script_row_t r;
        r.kind      = ROW_FRAMES;
        r.value     = 16'(v);
        r.last_flag = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    task automatic flag_mismatch(string what, page_outcome_t want, page_outcome_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: expected hit=%0d frame=%0d ev=%0d/%h faults=%0d,",
                      " got hit=%0d frame=%0d ev=%0d/%h faults=%0d"},
                     $realtime, what, want.hit, want.frame, want.ev_valid, want.ev_page,
                     want.faults, got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
    endtask

    // Enter and leave at a falling edge.
    task automatic send_access(page_t page, logic last_flag, logic typed, page_outcome_t want);
        page_outcome_t predicted;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        last_access <= last_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = lru_lookup(page, last_flag);
        pending_outcomes.push_back(typed ? want : predicted);
        accesses_sent++;
        @(negedge clk);
    endtask

    // Drain the core, then write frames_in_use over APB.
    task automatic write_frames(logic [CFG_W-1:0] v);
        logic [31:0] word;
        word           = $urandom();
        word[CFG_W-1:0] = v;
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(REG_FRAMES));
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames_setting = v;
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        page_outcome_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                seen = '{hit, frame_index, evicted_valid, evicted_page, fault_count};
                if (pending_outcomes.size() == 0)
                    flag_mismatch("unexpected result", '0, seen);
                else if (seen !== pending_outcomes[0])
                    flag_mismatch("result mismatch", pending_outcomes.pop_front(), seen);
                else
                    void'(pending_outcomes.pop_front());
            end
        end
    end

    initial
    begin
        script_row_t script[];
        page_t       pool[12];
        int          pool_size;
        int          seq_len;
        int          k;
        int          sel;
        logic        closes;
        logic        last_flag;
        page_t       page;

        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_valid       <= 1'b0;
        page_number    <= '0;
        last_access    <= 1'b0;
        accesses_sent  = 0;
        mismatch_count = 0;
        calm           = 1'b0;
        frames_setting = FRAMES_RESET;
        clear_frames();

        script = '{
            known_row(16'h0000, 0, 0, 0, 0, 16'h0000, 1),
            known_row(16'hFFFF, 0, 0, 1, 0, 16'h0000, 2),
            known_row(16'h0000, 0, 1, 0, 0, 16'h0000, 2),
            known_row(16'h0001, 0, 0, 2, 0, 16'h0000, 3),
            known_row(16'h0002, 0, 0, 3, 0, 16'h0000, 4),
            known_row(16'h0003, 0, 0, 4, 0, 16'h0000, 5),
            known_row(16'h0004, 0, 0, 5, 0, 16'h0000, 6),
            known_row(16'h0005, 0, 0, 6, 0, 16'h0000, 7),
            known_row(16'h0006, 0, 0, 7, 0, 16'h0000, 8),
            known_row(16'h8000, 0, 0, 1, 1, 16'hFFFF, 9),
            known_row(16'hFFFF, 0, 0, 0, 1, 16'h0000, 10),
            access_row(16'h0002, 0),
            access_row(16'h5555, 1),
            known_row(16'hFFFF, 0, 0, 0, 0, 16'h0000, 1),
            known_row(16'hAAAA, 1, 0, 1, 0, 16'h0000, 2),
            frames_row(1),
            known_row(16'h1234, 0, 0, 0, 0, 16'h0000, 1),
            known_row(16'h4321, 0, 0, 0, 1, 16'h1234, 2),
            known_row(16'h4321, 0, 1, 0, 0, 16'h0000, 2),
            known_row(16'h1234, 1, 0, 0, 1, 16'h4321, 3),
            frames_row(0),
            known_row(16'h0F0F, 0, 0, 0, 0, 16'h0000, 1),
            known_row(16'hF0F0, 1, 0, 0, 1, 16'h0F0F, 2),
            frames_row(4),
            access_row(16'h0100, 0),
            access_row(16'h0200, 0),
            access_row(16'h0300, 0),
            frames_row(2),
            access_row(16'h0300, 0),
            frames_row(4),
            access_row(16'h0300, 1),
            frames_row(15),
            access_row(16'h7FFF, 1)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_FRAMES: write_frames(script[i].value[CFG_W-1:0]);
                ROW_KNOWN:  send_access(script[i].value, script[i].last_flag, 1'b1,
                                        script[i].want);
                default:    send_access(script[i].value, script[i].last_flag, 1'b0, '0);
            endcase
        end

        while (accesses_sent < TOTAL_ACCESSES)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    write_frames(CFG_W'($urandom_range(1, NUM_FRAMES)));
                else if (sel < 7)
                    write_frames(CFG_W'(NUM_FRAMES));
                else
                    write_frames(CFG_W'($urandom_range(0, 15)));
            end
            pool_size = $urandom_range(1, 12);
            for (k = 0; k < pool_size; k++)
                pool[k] = page_t'($urandom());
            seq_len = $urandom_range(1, 40);
            closes  = ($urandom_range(0, 3) != 0);
            for (k = 0; k < seq_len; k++)
            begin
                if ($urandom_range(0, 6) == 0)
                    page = page_t'($urandom());
                else
                    page = pool[$urandom_range(0, pool_size - 1)];
                if (k == seq_len - 1)
                    last_flag = closes;
                else
                    last_flag = ($urandom_range(0, 39) == 0);
                send_access(page, last_flag, 1'b0, '0);
                if (accesses_sent >= TOTAL_ACCESSES - CALM_TAIL)
                    calm = 1'b1;
            end
        end

        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
